FILE: sv/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    localparam int MaxBoxesDefault = 64;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_IOU_NUM    = 2'd0;
    localparam logic [1:0] CFG_IOU_DEN    = 2'd1;
    localparam logic [1:0] CFG_KEEP_THRES = 2'd2;

    localparam logic [7:0]  IouNumReset    = 8'd2;
    localparam logic [7:0]  IouDenReset    = 8'd5;
    localparam logic [15:0] KeepThresReset = 16'd19661;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [7:0]         label;
        logic [15:0]        score;
        logic               final_box;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
        logic [7:0]         out_label;
        logic [15:0]        out_score;
        logic               box_valid;
        logic               overflowed;
        logic               end_of_set;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [7:0]         label;
        logic [15:0]        score;
    } t_box;

    typedef struct packed {
        logic load;        // store accepted beat
        logic i_clr;
        logic i_inc;
        logic j_inc;
        logic rd_box_i;    // box memory read at i
        logic rd_box_j;    // box memory read at j
        logic rd_box_rank; // box memory read at index held in rank entry
        logic rd_rank_i;
        logic rd_rank_j;
        logic rk_cap;      // latch score of i, restart j and rank count
        logic rk_wr;       // write rank entry for box i
        logic sp_cap_ref;  // latch reference box, j = i + 1
        logic sp_knock;    // mark entry j suppressed
        logic em_pend;     // park survivor
        logic em_out_pend; // move parked survivor to output
        logic em_end;      // final beat of the set, clear set state
    } t_cmd;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic knocked;
        logic survivor;
        logic have_pend;
        logic out_free;
        logic suppress;
    } t_status;

    typedef enum logic [4:0] {
        S_LOAD,
        S_RK_I, S_RK_IW, S_RK_J, S_RK_DR, S_RK_W,
        S_SP_I, S_SP_IR, S_SP_IB, S_SP_J, S_SP_JR, S_SP_JB,
        S_SP_M1, S_SP_M2, S_SP_M3, S_SP_M4,
        S_EM_I, S_EM_R, S_EM_B, S_EM_END
    } t_state;

endpackage
`default_nettype wire

FILE: sv/greedy_box_nms_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                    Beat
// in        input      i_in_valid / o_in_ready      gbn_pkg::t_in_item, one box
// out       output     o_out_valid / i_out_ready    gbn_pkg::t_out_item, one survivor
// cfg       input      i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// Boxes load at one beat a cycle. The beat with final_box closes the set; the
// input then stalls while n stored boxes are ranked, suppressed (each live
// reference box tested against the live boxes ranked below it) and emitted.
// The single read port of the box memory and the overlap pipeline, run one
// pair at a time, set the pace. A full output stage stalls the emit walk.
// Reset is synchronous, active low, and needs no clearing pass.
module greedy_box_nms_top #(
    parameter int MAX_BOXES = gbn_pkg::MaxBoxesDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire gbn_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output gbn_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);

    gbn_pkg::t_cmd    cmd;
    gbn_pkg::t_status st;

    // sequence load, rank, suppress and emit
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_final (i_in_item.final_box),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // stores, counters, overlap pipeline and output stage
    gbn_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

FILE: sv/gbn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_final,
    input  wire gbn_pkg::t_status i_st,
    output logic                 o_in_ready,
    output gbn_pkg::t_cmd        o_cmd
);

    gbn_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gbn_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_final) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = gbn_pkg::S_RK_I;
                    end
                end
            end
            gbn_pkg::S_RK_I: begin
                o_cmd.rd_box_i = 1'b1;
                n_state        = gbn_pkg::S_RK_IW;
            end
            gbn_pkg::S_RK_IW: begin
                o_cmd.rk_cap = 1'b1;
                n_state      = gbn_pkg::S_RK_J;
            end
            gbn_pkg::S_RK_J: begin
                o_cmd.rd_box_j = 1'b1;
                if (i_st.j_last) begin
                    n_state = gbn_pkg::S_RK_DR;
                end else begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            gbn_pkg::S_RK_DR: begin
                n_state = gbn_pkg::S_RK_W;
            end
            gbn_pkg::S_RK_W: begin
                o_cmd.rk_wr = 1'b1;
                if (i_st.i_last) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = gbn_pkg::S_SP_I;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = gbn_pkg::S_RK_I;
                end
            end
            gbn_pkg::S_SP_I: begin
                o_cmd.rd_rank_i = 1'b1;
                n_state         = gbn_pkg::S_SP_IR;
            end
            gbn_pkg::S_SP_IR: begin
                if (i_st.i_last) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = gbn_pkg::S_EM_I;
                end else if (i_st.knocked) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = gbn_pkg::S_SP_I;
                end else begin
                    o_cmd.rd_box_rank = 1'b1;
                    n_state           = gbn_pkg::S_SP_IB;
                end
            end
            gbn_pkg::S_SP_IB: begin
                o_cmd.sp_cap_ref = 1'b1;
                n_state          = gbn_pkg::S_SP_J;
            end
            gbn_pkg::S_SP_J: begin
                o_cmd.rd_rank_j = 1'b1;
                n_state         = gbn_pkg::S_SP_JR;
            end
            gbn_pkg::S_SP_JR: begin
                if (!i_st.knocked) begin
                    o_cmd.rd_box_rank = 1'b1;
                    n_state           = gbn_pkg::S_SP_JB;
                end else if (i_st.j_last) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = gbn_pkg::S_SP_I;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = gbn_pkg::S_SP_J;
                end
            end
            gbn_pkg::S_SP_JB: n_state = gbn_pkg::S_SP_M1;
            gbn_pkg::S_SP_M1: n_state = gbn_pkg::S_SP_M2;
            gbn_pkg::S_SP_M2: n_state = gbn_pkg::S_SP_M3;
            gbn_pkg::S_SP_M3: n_state = gbn_pkg::S_SP_M4;
            gbn_pkg::S_SP_M4: begin
                o_cmd.sp_knock = i_st.suppress;
                if (i_st.j_last) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = gbn_pkg::S_SP_I;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = gbn_pkg::S_SP_J;
                end
            end
            gbn_pkg::S_EM_I: begin
                o_cmd.rd_rank_i = 1'b1;
                n_state         = gbn_pkg::S_EM_R;
            end
            gbn_pkg::S_EM_R: begin
                if (!i_st.knocked) begin
                    o_cmd.rd_box_rank = 1'b1;
                    n_state           = gbn_pkg::S_EM_B;
                end else if (i_st.i_last) begin
                    n_state = gbn_pkg::S_EM_END;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = gbn_pkg::S_EM_I;
                end
            end
            gbn_pkg::S_EM_B: begin
                // hold a new survivor here while a parked one waits for the output stage
                if (!(i_st.survivor && i_st.have_pend && !i_st.out_free)) begin
                    if (i_st.survivor) begin
                        o_cmd.em_pend     = 1'b1;
                        o_cmd.em_out_pend = i_st.have_pend;
                    end
                    if (i_st.i_last) begin
                        n_state = gbn_pkg::S_EM_END;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state     = gbn_pkg::S_EM_I;
                    end
                end
            end
            gbn_pkg::S_EM_END: begin
                if (i_st.out_free) begin
                    o_cmd.em_end = 1'b1;
                    n_state      = gbn_pkg::S_LOAD;
                end
            end
            default: n_state = gbn_pkg::S_LOAD;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/gbn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_dp #(
    parameter int MAX_BOXES = gbn_pkg::MaxBoxesDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gbn_pkg::t_in_item  i_in_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_out_ready,
    input  wire gbn_pkg::t_cmd      i_cmd,
    output gbn_pkg::t_status        o_st,
    output logic                    o_out_valid,
    output gbn_pkg::t_out_item      o_out_item
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic          knocked;
        logic [IW-1:0] idx;
    } t_rank;

    gbn_pkg::t_box box_mem [MAX_BOXES];
    t_rank         rank_mem [MAX_BOXES];

    logic [7:0]  r_num, r_den;
    logic [15:0] r_thr;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [IW-1:0] r_i, r_j, r_acc, r_cmp_j;
    logic          r_cmp_v;
    logic [15:0]   r_score_i;
    gbn_pkg::t_box r_box_q, r_ref, r_pend;
    t_rank         r_rank_q;
    logic          r_have_pend;
    logic          r_out_v;
    gbn_pkg::t_out_item r_out;

    logic [IW-1:0] last_idx;
    logic [IW-1:0] box_raddr, rank_raddr;

    // overlap pipeline
    logic signed [16:0] r_w, r_h, r_dxa, r_dya, r_dxb, r_dyb;
    logic signed [33:0] r_inter2, r_area_a, r_area_b;
    logic signed [35:0] r_inter3, r_uni3;
    logic signed [44:0] r_lhs, r_rhs;
    logic               r_uni_pos;
    logic signed [15:0] min_r, max_l, min_b, max_t;
    logic signed [33:0] w34, h34, dxa34, dya34, dxb34, dyb34;
    logic signed [35:0] ia36, ib36, ii36;
    logic signed [44:0] inter45, uni45, num45, den45;

    assign last_idx = IW'(r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= gbn_pkg::IouNumReset;
            r_den <= gbn_pkg::IouDenReset;
            r_thr <= gbn_pkg::KeepThresReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbn_pkg::CFG_IOU_NUM:    r_num <= i_cfg_data[7:0];
                gbn_pkg::CFG_IOU_DEN:    r_den <= i_cfg_data[7:0];
                gbn_pkg::CFG_KEEP_THRES: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    always_comb begin
        priority if (i_cmd.rd_box_i) begin
            box_raddr = r_i;
        end else if (i_cmd.rd_box_j) begin
            box_raddr = r_j;
        end else begin
            box_raddr = r_rank_q.idx;
        end
        rank_raddr = i_cmd.rd_rank_j ? r_j : r_i;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count != CW'(MAX_BOXES))) begin
            box_mem[r_count[IW-1:0]] <= '{left: i_in_item.left, top: i_in_item.top,
                                          right: i_in_item.right,
                                          bottom: i_in_item.bottom,
                                          label: i_in_item.label,
                                          score: i_in_item.score};
        end
        if (i_cmd.rd_box_i || i_cmd.rd_box_j || i_cmd.rd_box_rank) begin
            r_box_q <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rk_wr) begin
            rank_mem[r_acc] <= '{knocked: 1'b0, idx: r_i};
        end else if (i_cmd.sp_knock) begin
            rank_mem[r_j] <= '{knocked: 1'b1, idx: r_rank_q.idx};
        end
        if (i_cmd.rd_rank_i || i_cmd.rd_rank_j) begin
            r_rank_q <= rank_mem[rank_raddr];
        end
    end

    // set bookkeeping and output-stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_have_pend <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count == CW'(MAX_BOXES)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            r_cmp_v <= i_cmd.rd_box_j;
            if (i_cmd.em_pend) begin
                r_have_pend <= 1'b1;
            end
            if (i_cmd.em_end) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_have_pend <= 1'b0;
            end
            if (i_cmd.em_out_pend || i_cmd.em_end) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IW'(1);
        end
        if (i_cmd.rk_cap) begin
            r_j       <= '0;
            r_acc     <= '0;
            r_score_i <= r_box_q.score;
        end else if (i_cmd.sp_cap_ref) begin
            r_j   <= r_i + IW'(1);
            r_ref <= r_box_q;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IW'(1);
        end
        r_cmp_j <= r_j;
        // count boxes that rank ahead of box i
        if (r_cmp_v && ((r_box_q.score > r_score_i) ||
                        ((r_box_q.score == r_score_i) && (r_cmp_j < r_i)))) begin
            r_acc <= r_acc + IW'(1);
        end
        if (i_cmd.em_pend) begin
            r_pend <= r_box_q;
        end
        if (i_cmd.em_out_pend || (i_cmd.em_end && r_have_pend)) begin
            r_out <= '{out_left: r_pend.left, out_top: r_pend.top,
                       out_right: r_pend.right, out_bottom: r_pend.bottom,
                       out_label: r_pend.label, out_score: r_pend.score,
                       box_valid: 1'b1, overflowed: r_ovf, end_of_set: i_cmd.em_end};
        end else if (i_cmd.em_end) begin
            r_out <= '{box_valid: 1'b0, overflowed: r_ovf, end_of_set: 1'b1,
                       default: '0};
        end
    end

    // overlap test, one stage per cycle
    always_comb begin
        min_r = (r_ref.right  < r_box_q.right)  ? r_ref.right  : r_box_q.right;
        max_l = (r_ref.left   > r_box_q.left)   ? r_ref.left   : r_box_q.left;
        min_b = (r_ref.bottom < r_box_q.bottom) ? r_ref.bottom : r_box_q.bottom;
        max_t = (r_ref.top    > r_box_q.top)    ? r_ref.top    : r_box_q.top;
        w34   = 34'(r_w);
        h34   = 34'(r_h);
        dxa34 = 34'(r_dxa);
        dya34 = 34'(r_dya);
        dxb34 = 34'(r_dxb);
        dyb34 = 34'(r_dyb);
        ia36  = 36'(r_area_a);
        ib36  = 36'(r_area_b);
        ii36  = 36'(r_inter2);
        inter45 = 45'(r_inter3);
        uni45   = 45'(r_uni3);
        num45   = 45'($signed({1'b0, r_num}));
        den45   = 45'($signed({1'b0, r_den}));
    end

    always_ff @(posedge i_clk) begin
        r_w   <= 17'(min_r) - 17'(max_l);
        r_h   <= 17'(min_b) - 17'(max_t);
        r_dxa <= 17'(r_ref.right)    - 17'(r_ref.left);
        r_dya <= 17'(r_ref.bottom)   - 17'(r_ref.top);
        r_dxb <= 17'(r_box_q.right)  - 17'(r_box_q.left);
        r_dyb <= 17'(r_box_q.bottom) - 17'(r_box_q.top);

        r_inter2 <= (r_w < 17'sd0 || r_h < 17'sd0) ? 34'sd0 : w34 * h34;
        r_area_a <= dya34 * dxa34;
        r_area_b <= dyb34 * dxb34;

        r_inter3 <= ii36;
        r_uni3   <= ia36 + ib36 - ii36;

        r_lhs     <= inter45 * den45;
        r_rhs     <= num45 * uni45;
        r_uni_pos <= r_uni3 > 36'sd0;
    end

    always_comb begin
        o_st.i_last    = r_i == last_idx;
        o_st.j_last    = r_j == last_idx;
        o_st.knocked   = r_rank_q.knocked;
        o_st.survivor  = r_box_q.score >= r_thr;
        o_st.have_pend = r_have_pend;
        o_st.out_free  = !r_out_v;
        o_st.suppress  = r_uni_pos && (r_lhs >= r_rhs);
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES))
        else $error("box count beyond capacity");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.em_end |=> (r_count == '0) && !r_ovf && !r_have_pend)
        else $error("set state not cleared after final beat");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rk_wr |-> (CW'(r_acc) < r_count))
        else $error("rank outside stored set");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.em_out_pend || i_cmd.em_end) |-> !r_out_v)
        else $error("output stage overwritten while full");

endmodule
`default_nettype wire

FILE: tb/tb_greedy_box_nms_top.sv
`timescale 1ns / 1ps

// Tracks the configuration and the box set as the block sees it, and works out
// which survivors each closed set must produce, in emit order.
class survivor_board;
    gbn_pkg::t_box       held_boxes[gbn_pkg::MaxBoxesDefault];
    int                  held_count;
    bit                  dropped_any;
    logic [7:0]          iou_num;
    logic [7:0]          iou_den;
    logic [15:0]         keep_thres;
    gbn_pkg::t_out_item  survivors_due[$];
    int                  fault_count;

    function new();
        held_count  = 0;
        dropped_any = 0;
        iou_num     = gbn_pkg::IouNumReset;
        iou_den     = gbn_pkg::IouDenReset;
        keep_thres  = gbn_pkg::KeepThresReset;
        fault_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            gbn_pkg::CFG_IOU_NUM:    iou_num    = data[7:0];
            gbn_pkg::CFG_IOU_DEN:    iou_den    = data[7:0];
            gbn_pkg::CFG_KEEP_THRES: keep_thres = data;
            default: ;
        endcase
    endfunction

    function bit overlaps_enough(gbn_pkg::t_box a, gbn_pkg::t_box b);
        longint al, at, ar, ab, bl, bt, br, bb, w, h, inter, area_a, area_b, uni;
        al = a.left; at = a.top; ar = a.right; ab = a.bottom;
        bl = b.left; bt = b.top; br = b.right; bb = b.bottom;
        w = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        h = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        inter = (w < 0 || h < 0) ? 0 : w * h;
        area_a = (ab - at) * (ar - al);
        area_b = (bb - bt) * (br - bl);
        uni = area_a + area_b - inter;
        if (uni <= 0) return 0;
        return inter * longint'(iou_den) >= longint'(iou_num) * uni;
    endfunction

    // Rank by descending score (stable), suppress greedily, emit the keepers.
    function void rank_and_suppress();
        int rank[gbn_pkg::MaxBoxesDefault];
        bit knocked[gbn_pkg::MaxBoxesDefault];
        int i, j, emitted;
        gbn_pkg::t_out_item r;
        for (i = 0; i < held_count; i++) begin
            j = i;
            while (j > 0 && held_boxes[rank[j-1]].score < held_boxes[i].score) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = i;
            knocked[i] = 0;
        end
        for (i = 0; i < held_count; i++) begin
            if (knocked[i]) continue;
            for (j = i + 1; j < held_count; j++)
                if (!knocked[j] && overlaps_enough(held_boxes[rank[i]], held_boxes[rank[j]]))
                    knocked[j] = 1;
        end
        emitted = 0;
        for (i = 0; i < held_count; i++) begin
            if (knocked[i] || held_boxes[rank[i]].score < keep_thres) continue;
            r.out_left   = held_boxes[rank[i]].left;
            r.out_top    = held_boxes[rank[i]].top;
            r.out_right  = held_boxes[rank[i]].right;
            r.out_bottom = held_boxes[rank[i]].bottom;
            r.out_label  = held_boxes[rank[i]].label;
            r.out_score  = held_boxes[rank[i]].score;
            r.box_valid  = 1'b1;
            r.overflowed = dropped_any;
            r.end_of_set = 1'b0;
            survivors_due = {survivors_due, r};
            emitted++;
        end
        if (emitted == 0) begin
            r = '0;
            r.overflowed = dropped_any;
            survivors_due = {survivors_due, r};
        end
        survivors_due[survivors_due.size()-1].end_of_set = 1'b1;
        held_count  = 0;
        dropped_any = 0;
    endfunction

    function void note_box(gbn_pkg::t_in_item it);
        if (held_count < gbn_pkg::MaxBoxesDefault) begin
            held_boxes[held_count] = {it.left, it.top, it.right, it.bottom, it.label, it.score};
            held_count++;
        end else begin
            dropped_any = 1;
        end
        if (it.final_box) rank_and_suppress();
    endfunction

    function void check_result(gbn_pkg::t_out_item got, realtime now);
        gbn_pkg::t_out_item want;
        if (survivors_due.size() == 0) begin
            $display("%0t: unexpected result %h", now, got);
            fault_count++;
            return;
        end
        want = survivors_due.pop_front();
        if (got.out_left !== want.out_left || got.out_top !== want.out_top ||
            got.out_right !== want.out_right || got.out_bottom !== want.out_bottom ||
            got.out_label !== want.out_label || got.out_score !== want.out_score ||
            got.box_valid !== want.box_valid || got.overflowed !== want.overflowed ||
            got.end_of_set !== want.end_of_set) begin
            $display("%0t: mismatch expected l=%0d t=%0d r=%0d b=%0d lab=%0d sc=%0d v=%b o=%b e=%b",
                     now, want.out_left, want.out_top, want.out_right, want.out_bottom,
                     want.out_label, want.out_score, want.box_valid, want.overflowed,
                     want.end_of_set);
            $display("%0t: mismatch actual   l=%0d t=%0d r=%0d b=%0d lab=%0d sc=%0d v=%b o=%b e=%b",
                     now, got.out_left, got.out_top, got.out_right, got.out_bottom,
                     got.out_label, got.out_score, got.box_valid, got.overflowed,
                     got.end_of_set);
            fault_count++;
        end
    endfunction
endclass

module tb_greedy_box_nms_top;
    // cycle limit for the whole run, with plenty of headroom
    localparam int CycleLimit = 1000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    gbn_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    gbn_pkg::t_out_item o_out_item;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    survivor_board board;
    bit          calm;        // set for the closing stretch: no idling at all
    int          cycles;
    int          sent;

    greedy_box_nms_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung block must not stall the run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Note every accepted box and check every accepted result at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) board.note_box(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_out_item, $realtime);
    end

    // Receiver: stall in random bursts, with quiet stretches between.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(0, 12)) begin
                    @(negedge i_clk);
                end
            end
        end
    end

    // Drive one beat; hold valid and payload until the block takes it. Valid
    // stays high after the edge; the next beat, an idle burst or drain() moves it.
    task automatic send_box(gbn_pkg::t_in_item it);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // Drop valid, wait for every expected survivor, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.survivors_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic set_config(logic [7:0] num, logic [7:0] den, logic [15:0] thres);
        drain();
        write_reg(gbn_pkg::CFG_IOU_NUM, {8'd0, num});
        write_reg(gbn_pkg::CFG_IOU_DEN, {8'd0, den});
        write_reg(gbn_pkg::CFG_KEEP_THRES, thres);
    endtask

    function automatic gbn_pkg::t_in_item make_box(logic signed [15:0] l,
                                                   logic signed [15:0] t,
                                                   logic signed [15:0] r,
                                                   logic signed [15:0] b,
                                                   logic [7:0] lab, logic [15:0] sc,
                                                   logic fin);
        gbn_pkg::t_in_item it;
        it.left = l; it.top = t; it.right = r; it.bottom = b;
        it.label = lab; it.score = sc; it.final_box = fin;
        return it;
    endfunction

    // Random box: mostly clustered near a centre so that overlaps happen,
    // sometimes fully random corners across the whole range.
    function automatic gbn_pkg::t_in_item rand_box(int cx, int cy, logic fin);
        int w, h, x, y;
        logic [15:0] sc;
        if ($urandom_range(0, 7) == 0) begin
            return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom), 16'($urandom), fin);
        end
        x = cx + $urandom_range(0, 40) - 20;
        y = cy + $urandom_range(0, 40) - 20;
        w = $urandom_range(0, 60);
        h = $urandom_range(0, 60);
        if ($urandom_range(0, 19) == 0) w = -w;
        // ties are common on purpose
        sc = ($urandom_range(0, 3) == 0) ? 16'(32768 + 4096 * $urandom_range(0, 7))
                                         : 16'($urandom);
        return make_box(16'(x), 16'(y), 16'(x + w), 16'(y + h), 8'($urandom), sc, fin);
    endfunction

    task automatic send_set(int n);
        int cx, cy;
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                cx = $urandom_range(0, 60000) - 30000;
                cy = $urandom_range(0, 60000) - 30000;
            end
            send_box(rand_box(cx, cy, k == n - 1));
        end
    endtask

    initial begin
        board       = new();
        calm        = 0;
        cycles      = 0;
        sent        = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = gbn_pkg::CFG_IOU_NUM;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme corners, a tied duplicate that gets suppressed,
        // inverted corners, a point box, and a box below the threshold.
        send_box(make_box(-32768, -32768, 32767, 32767, 8'd255, 16'hFFFF, 1'b0));
        send_box(make_box(-32768, -32768, 32767, 32767, 8'd0, 16'hFFFF, 1'b0));
        send_box(make_box(32767, 32767, -32768, -32768, 8'd7, 16'hFFFF, 1'b0));
        send_box(make_box(5, 5, 5, 5, 8'd1, 16'd40000, 1'b0));
        send_box(make_box(0, 0, 0, 0, 8'd0, 16'd0, 1'b1));
        // nothing survives the threshold: empty end marker
        send_box(make_box(10, 10, 20, 20, 8'd3, 16'd19660, 1'b1));
        // exactly at threshold, disjoint boxes, equal scores keep arrival order
        send_box(make_box(0, 0, 10, 10, 8'd1, 16'd19661, 1'b0));
        send_box(make_box(100, 100, 110, 110, 8'd2, 16'd19661, 1'b0));
        send_box(make_box(-50, -50, -40, -40, 8'd3, 16'd50000, 1'b1));
        // partial overlap: one pair above the default limit (2/5), one pair below it
        send_box(make_box(0, 0, 10, 10, 8'd4, 16'd60000, 1'b0));
        send_box(make_box(0, 0, 10, 7, 8'd5, 16'd50000, 1'b0));
        send_box(make_box(0, 5, 10, 15, 8'd6, 16'd40000, 1'b1));
        // chain of half-overlapping boxes, each pair below the default limit: all three survive
        send_box(make_box(0, 0, 10, 10, 8'd7, 16'd60000, 1'b0));
        send_box(make_box(5, 0, 15, 10, 8'd8, 16'd50000, 1'b0));
        send_box(make_box(10, 0, 20, 10, 8'd9, 16'd40000, 1'b1));

        // Config sweeps, extremes included, with random sets in each phase.
        set_config(8'd0, 8'd1, 16'd0);
        while (sent < 70) send_set($urandom_range(1, 8));
        // overflow: the 65th box is dropped yet still closes the set
        send_set(65);
        set_config(8'd255, 8'd1, 16'hFFFF);
        while (sent < 160) send_set($urandom_range(1, 8));
        set_config(8'd1, 8'd2, 16'd0);
        send_set(67);
        while (sent < 210) send_set($urandom_range(1, 8));
        set_config(8'd3, 8'd0, 16'd30000);
        while (sent < 240) send_set($urandom_range(1, 6));
        set_config(8'd255, 8'd255, 16'd100);
        while (sent < 260) send_set($urandom_range(1, 6));
        set_config(gbn_pkg::IouNumReset, gbn_pkg::IouDenReset, gbn_pkg::KeepThresReset);
        calm = 1;
        while (sent < 280) send_set($urandom_range(1, 8));

        drain();
        repeat (50) @(posedge i_clk);
        if (board.fault_count == 0 && board.survivors_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
